[design/gh_pkg.sv]
`timescale 1ns / 1ps
// gh_pkg: constants, types and the base32 alphabet for the geohash encoder
// no dependencies; imported by geohash_encoder

package gh_pkg;

    // fixed point format and bisection depth
    localparam int FRAC_BITS  = 24;
    localparam int MAX_BPC    = 30;
    localparam int MIN_BPC    = 3;

    // field widths
    localparam int LAT_W      = 32;
    localparam int LON_W      = 33;
    localparam int BPC_W      = 5;
    localparam int CHAR_W     = 7;
    localparam int GROUP_BITS = 5;

    // bit buffer and counters
    localparam int BUF_W      = 2 * MAX_BPC;
    localparam int CNT_W      = $clog2(BUF_W + 1);

    // bounds carry MAX_BPC extra fraction bits so every midpoint is exact
    localparam int BND_W      = 64;

    localparam logic signed [LAT_W-1:0] LAT_LIMIT = LAT_W'(64'(90) << FRAC_BITS);
    localparam logic signed [LON_W-1:0] LON_LIMIT = LON_W'(64'(180) << FRAC_BITS);

    // first latitude step: a quarter of the full span; longitude uses twice this
    localparam logic [BND_W-1:0] DELTA_INIT =
        BND_W'(64'(90) << (FRAC_BITS + MAX_BPC - 1));

    // configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_BPC = APB_ADDR_W'(0);
    localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(20);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BISECT,
        ST_EMIT,
        ST_ERROR
    } gh_state_t;

    typedef logic [CHAR_W-1:0] char_t;

    // geohash base32 alphabet, ascii codes
    localparam char_t ALPHABET [32] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
    };

endpackage

[design/geohash_encoder.sv]
`timescale 1ns / 1ps
// geohash_encoder: latitude/longitude to geohash base32 characters
// depends on gh_pkg
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ----------------------------------
//  input     in         in_valid / in_stall   latitude, longitude
//  output    out        out_valid / out_stall hash_char, last_char, range_error
//  config    in         apb write/read        bits_per_coord at byte address 0
//
// each word in runs 2*b bisection steps (b = bits_per_coord clamped to 3..30),
// one coordinate step per cycle through the shared compare/add unit, then one
// character word per cycle as long as the output is not stalled, then the block
// returns to idle, where the next word can be taken. an out of range word skips
// bisection and gives its single error word in the cycle after acceptance. an
// output stall holds the current word and delays the return to idle.
// in_stall is high from the cycle after acceptance until the last word of that
// location has been taken. reset (rst_n, async, low) returns to idle with
// bits_per_coord = 20; there is no clearing pass.

module geohash_encoder
    import gh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [LAT_W-1:0]  latitude,
    input  logic signed [LON_W-1:0]  longitude,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CHAR_W-1:0]        hash_char,
    output logic                     last_char,
    output logic                     range_error,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready
);

    // control state
    gh_state_t               state_reg, state_next;
    logic [BPC_W-1:0]        bpc_reg;
    logic                    coord_reg;      // 0: longitude step, 1: latitude step
    logic [CNT_W-1:0]        bit_cnt_reg;    // bits produced so far
    logic [CNT_W-1:0]        total_reg;      // 2*b for the current word
    logic [CNT_W-1:0]        rem_reg;        // bits still to be sent as characters

    // payload state
    logic signed [LAT_W-1:0] lat_reg;
    logic signed [LON_W-1:0] lon_reg;
    logic signed [BND_W-1:0] lat_mid_reg;
    logic signed [BND_W-1:0] lon_mid_reg;
    logic        [BND_W-1:0] delta_reg;
    logic        [BUF_W-1:0] buf_reg;        // msb-aligned: first bit at the top

    logic                    in_fire;
    logic                    out_fire;
    logic                    cfg_write;
    logic                    range_bad;
    logic [BPC_W-1:0]        bpc_eff;
    logic [CNT_W-1:0]        total_eff;
    logic                    bisect_done;
    logic                    emit_last;

    // shared bisection unit
    logic signed [BND_W-1:0] lat_scaled;
    logic signed [BND_W-1:0] lon_scaled;
    logic signed [BND_W-1:0] sel_val;
    logic signed [BND_W-1:0] sel_mid;
    logic signed [BND_W-1:0] sel_delta;
    logic signed [BND_W-1:0] mid_new;
    logic                    below;
    logic [CNT_W-1:0]        bit_pos;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_BPC);

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_BPC)
        begin
            prdata = APB_DATA_W'(bpc_reg);
        end
    end

    // clamp to the supported bisection depth
    always_comb
    begin
        priority if (bpc_reg < BPC_W'(MIN_BPC))
        begin
            bpc_eff = BPC_W'(MIN_BPC);
        end
        else if (bpc_reg > BPC_W'(MAX_BPC))
        begin
            bpc_eff = BPC_W'(MAX_BPC);
        end
        else
        begin
            bpc_eff = bpc_reg;
        end
    end

    assign total_eff = CNT_W'({bpc_eff, 1'b0});

    // ------------------------------------------------------------------
    // handshake and range check
    // ------------------------------------------------------------------
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;
    assign range_bad = (latitude > LAT_LIMIT) || (latitude < -LAT_LIMIT) ||
                       (longitude > LON_LIMIT) || (longitude < -LON_LIMIT);

    assign bisect_done = (bit_cnt_reg == total_reg - CNT_W'(1));
    // fewer than two whole groups left means this is the final character
    assign emit_last   = (rem_reg < CNT_W'(2 * GROUP_BITS));

    // ------------------------------------------------------------------
    // shared compare/add unit: one coordinate step per cycle,
    // longitude first, then latitude
    // ------------------------------------------------------------------
    assign lat_scaled = BND_W'(lat_reg) <<< MAX_BPC;
    assign lon_scaled = BND_W'(lon_reg) <<< MAX_BPC;
    assign sel_val    = coord_reg ? lat_scaled  : lon_scaled;
    assign sel_mid    = coord_reg ? lat_mid_reg : lon_mid_reg;
    // longitude span is twice the latitude span at every step
    assign sel_delta  = coord_reg ? $signed(delta_reg) : $signed(delta_reg << 1);
    assign below      = (sel_val < sel_mid);
    assign mid_new    = below ? (sel_mid - sel_delta) : (sel_mid + sel_delta);
    assign bit_pos    = CNT_W'(BUF_W - 1) - bit_cnt_reg;

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = range_bad ? ST_ERROR : ST_BISECT;
                end
            end
            ST_BISECT:
            begin
                if (bisect_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        hash_char   = ALPHABET[buf_reg[BUF_W-1 -: GROUP_BITS]];
        last_char   = emit_last;
        range_error = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_BISECT:
            begin
                in_stall = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
            end
            ST_ERROR:
            begin
                out_valid   = 1'b1;
                hash_char   = '0;
                last_char   = 1'b1;
                range_error = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bpc_reg     <= BPC_RESET;
            coord_reg   <= 1'b0;
            bit_cnt_reg <= '0;
            total_reg   <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                bpc_reg <= pwdata[BPC_W-1:0];
            end
            if (in_fire)
            begin
                coord_reg   <= 1'b0;
                bit_cnt_reg <= '0;
                total_reg   <= total_eff;
                rem_reg     <= total_eff;
            end
            else if (state_reg == ST_BISECT)
            begin
                coord_reg   <= !coord_reg;
                bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
            end
            else if ((state_reg == ST_EMIT) && out_fire)
            begin
                rem_reg <= rem_reg - CNT_W'(GROUP_BITS);
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg     <= '0;
            lon_reg     <= '0;
            lat_mid_reg <= '0;
            lon_mid_reg <= '0;
            delta_reg   <= '0;
            buf_reg     <= '0;
        end
        else if (in_fire)
        begin
            lat_reg     <= latitude;
            lon_reg     <= longitude;
            lat_mid_reg <= '0;
            lon_mid_reg <= '0;
            delta_reg   <= DELTA_INIT;
            buf_reg     <= '0;
        end
        else if (state_reg == ST_BISECT)
        begin
            buf_reg[bit_pos] <= !below;
            if (coord_reg)
            begin
                lat_mid_reg <= mid_new;
                delta_reg   <= delta_reg >> 1;
            end
            else
            begin
                lon_mid_reg <= mid_new;
            end
        end
        else if ((state_reg == ST_EMIT) && out_fire)
        begin
            buf_reg <= buf_reg << GROUP_BITS;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BISECT) |-> (bit_cnt_reg < total_reg))
        else $error("bit counter ran past the bisection length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg >= CNT_W'(GROUP_BITS)))
        else $error("character sent with less than a whole group left");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BISECT) && bisect_done) |=> (state_reg == ST_EMIT))
        else $error("bisection end did not start character output");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_fire && !emit_last) |=>
        ((state_reg == ST_EMIT) && (rem_reg == $past(rem_reg) - CNT_W'(GROUP_BITS))))
        else $error("character output stopped early or skipped a group");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && range_bad) |=> (state_reg == ST_ERROR))
        else $error("out of range word did not give an error word");

endmodule

[sim/geohash_encoder_test.sv]
`timescale 1ns / 1ps
// geohash_encoder_test: self-checking bench for the geohash encoder
// depends on gh_pkg and geohash_encoder; drives words, checks every character against its own encoder or a typed word

module geohash_encoder_test;
    import gh_pkg::*;

    // ------------------------------------------------------------------
    // bench constants
    // ------------------------------------------------------------------
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     DRAIN_CYCLES = 80;
    localparam int     HOLD_CYCLES  = 300;       // long receiver hold-off
    localparam int     N_PROBES     = 24;
    localparam int     N_PHASES     = 7;
    localparam int     PHASE_WORDS  = 40;
    localparam int     PRESSURE_PH  = 2;         // phase that carries the long hold-off
    localparam int     BURST_PH     = 1;         // phase with no sender gaps

    // degree limits and bound scaling, own copies
    localparam longint LAT_LIM   = longint'(90) << FRAC_BITS;
    localparam longint LON_LIM   = longint'(180) << FRAC_BITS;
    localparam longint BND_SCALE = longint'(1) << MAX_BPC;

    localparam string  GH_DIGITS = "0123456789bcdefghjkmnpqrstuvwxyz";

    // error word carries no character
    localparam char_t  ERR_CHAR  = '0;
    localparam char_t  CHAR_S    = 7'h73;        // 's', the cell holding 0,0

    typedef struct {
        char_t ch;
        logic  last;
        logic  err;
    } geo_word_t;

    typedef struct {
        int     bpc;
        longint lat;
        longint lon;
        bit     known;      // expected single word typed in below
        char_t  k_char;
        bit     k_err;
    } probe_t;

    // ------------------------------------------------------------------
    // dut signals, all bench-driven ones set to known values from time zero
    // ------------------------------------------------------------------
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic signed [LAT_W-1:0] latitude    = '0;
    logic signed [LON_W-1:0] longitude   = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [CHAR_W-1:0]       hash_char;
    logic                    last_char;
    logic                    range_error;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr       = '0;
    logic [APB_DATA_W-1:0]   pwdata      = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // typed expectation travels with the payload of the current word
    logic                    word_known  = 1'b0;
    char_t                   word_k_char = '0;
    logic                    word_k_err  = 1'b0;

    // bench state
    geo_word_t               hash_q [$];        // characters still owed by the block
    logic [BPC_W-1:0]        bpc_shadow  = BPC_RESET;
    int                      mismatch_cnt = 0;
    int                      cycle_cnt    = 0;
    bit                      pressure_go  = 1'b0;
    bit                      long_hold    = 1'b0;
    int                      stall_left   = 0;
    bit                      stall_run    = 1'b0;
    probe_t                  probes [N_PROBES];

    geohash_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .latitude   (latitude),
        .longitude  (longitude),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_char  (hash_char),
        .last_char  (last_char),
        .range_error(range_error),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // geohash encoder model: bisect both coordinates, interleave
    // longitude first, cut into 5-bit groups msb first
    // ------------------------------------------------------------------
    task automatic predict_hash(input logic signed [LAT_W-1:0] lat,
                                input logic signed [LON_W-1:0] lon);
        int unsigned      steps;
        int unsigned      total;
        int unsigned      nchar;
        int unsigned      spare;
        int unsigned      sh;
        longint           la;
        longint           lo;
        longint           lat_lo;
        longint           lat_hi;
        longint           lon_lo;
        longint           lon_hi;
        longint           mid;
        logic [BUF_W-1:0] bits;
        logic [4:0]       idx;
        geo_word_t        w;

        la = longint'(lat);
        lo = longint'(lon);

        // out of range: one error word, no bisection
        if (la > LAT_LIM || la < -LAT_LIM || lo > LON_LIM || lo < -LON_LIM) begin
            w.ch   = ERR_CHAR;
            w.last = 1'b1;
            w.err  = 1'b1;
            hash_q.insert(hash_q.size(), w);
            return;
        end

        // register value is clamped only where it is used
        steps = bpc_shadow;
        if (steps < MIN_BPC)
            steps = MIN_BPC;
        if (steps > MAX_BPC)
            steps = MAX_BPC;

        la     = la * BND_SCALE;
        lo     = lo * BND_SCALE;
        lat_lo = -LAT_LIM * BND_SCALE;
        lat_hi =  LAT_LIM * BND_SCALE;
        lon_lo = -LON_LIM * BND_SCALE;
        lon_hi =  LON_LIM * BND_SCALE;
        bits   = '0;

        for (int i = 0; i < steps; i++) begin
            mid = (lon_lo + lon_hi) / 2;
            if (lo < mid) begin
                lon_hi = mid;
                bits   = {bits[BUF_W-2:0], 1'b0};
            end
            else begin
                lon_lo = mid;
                bits   = {bits[BUF_W-2:0], 1'b1};
            end
            mid = (lat_lo + lat_hi) / 2;
            if (la < mid) begin
                lat_hi = mid;
                bits   = {bits[BUF_W-2:0], 1'b0};
            end
            else begin
                lat_lo = mid;
                bits   = {bits[BUF_W-2:0], 1'b1};
            end
        end

        // leftover bits below the last whole group are dropped
        total = 2 * steps;
        nchar = total / GROUP_BITS;
        spare = total % GROUP_BITS;
        for (int unsigned i = 0; i < nchar; i++) begin
            sh     = spare + GROUP_BITS * (nchar - 1 - i);
            idx    = bits[sh +: 5];
            w.ch   = char_t'(GH_DIGITS[idx]);
            w.last = (i + 1 == nchar);
            w.err  = 1'b0;
            hash_q.insert(hash_q.size(), w);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge, in one process
    // so a prediction is always queued before its first character
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        geo_word_t w;
        geo_word_t exp_w;

        if (rst_n && in_valid && !in_stall) begin
            if (word_known) begin
                w.ch   = word_k_char;
                w.last = 1'b1;
                w.err  = word_k_err;
                hash_q.insert(hash_q.size(), w);
            end
            else
                predict_hash(latitude, longitude);
        end

        if (rst_n && out_valid && !out_stall) begin
            if (hash_q.size() == 0)
                flag_mismatch($sformatf("unexpected word char %h last %b err %b",
                                        hash_char, last_char, range_error));
            else begin
                exp_w = hash_q.pop_front();
                if (hash_char !== exp_w.ch)
                    flag_mismatch($sformatf("hash_char got %h want %h",
                                            hash_char, exp_w.ch));
                if (last_char !== exp_w.last)
                    flag_mismatch($sformatf("last_char got %b want %b",
                                            last_char, exp_w.last));
                if (range_error !== exp_w.err)
                    flag_mismatch($sformatf("range_error got %b want %b",
                                            range_error, exp_w.err));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall runs, mostly short, a few long, some long
    // free-flowing stretches; long_hold forces a stretch of stall
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        int r;
        if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                stall_run  = 1'b0;
                stall_left = $urandom_range(1, 30);
            end
            else if (r < 88) begin
                stall_run  = 1'b1;
                stall_left = $urandom_range(1, 3);
            end
            else if (r < 96) begin
                stall_run  = 1'b1;
                stall_left = $urandom_range(10, 40);
            end
            else begin
                stall_run  = 1'b0;
                stall_left = $urandom_range(60, 150);
            end
        end
        stall_left--;
        out_stall <= long_hold || stall_run;
    end

    // long hold-off, counted on its own while the sender keeps offering
    initial begin
        wait (pressure_go);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // config port: setup then access, completes when pready is high
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_BPC;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read back the register and compare with the shadow copy
    task automatic check_bpc();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(bpc_shadow))
            flag_mismatch($sformatf("bits_per_coord read %0d want %0d", rd, bpc_shadow));
    endtask

    task automatic set_bpc(input int value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, APB_DATA_W'(value), rd);
        bpc_shadow = BPC_W'(value);
        check_bpc();
    endtask

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_word(input logic signed [LAT_W-1:0] lat,
                             input logic signed [LON_W-1:0] lon,
                             input bit known, input char_t k_char, input bit k_err,
                             input int gap);
        @(negedge clk);
        in_valid    <= 1'b1;
        latitude    <= lat;
        longitude   <= lon;
        word_known  <= known;
        word_k_char <= k_char;
        word_k_err  <= k_err;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drop valid and wait for every owed character
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (hash_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap(input bit no_gaps);
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint uniform_coord(input longint lim);
        longint r;
        r = {$urandom, $urandom};
        r = r & 64'h7fff_ffff_ffff_ffff;
        return (r % (2 * lim + 1)) - lim;
    endfunction

    // values on and around the interval edges and the first midpoint
    function automatic longint edge_coord(input longint lim);
        case ($urandom_range(0, 8))
            0: return lim;
            1: return -lim;
            2: return lim - 1;
            3: return -lim + 1;
            4: return 0;
            5: return -1;
            6: return 1;
            7: return lim + 1;
            default: return -lim - 1;
        endcase
    endfunction

    task automatic make_location(output logic signed [LAT_W-1:0] lat,
                                 output logic signed [LON_W-1:0] lon);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // raw bits, about half out of range
            lat = $urandom;
            lon = {1'($urandom_range(0, 1)), 32'($urandom)};
        end
        else if (r < 18) begin
            lat = LAT_W'(($urandom_range(0, 1) == 0) ? edge_coord(LAT_LIM)
                                                     : uniform_coord(LAT_LIM));
            lon = LON_W'(($urandom_range(0, 1) == 0) ? edge_coord(LON_LIM)
                                                     : uniform_coord(LON_LIM));
        end
        else begin
            lat = LAT_W'(uniform_coord(LAT_LIM));
            lon = LON_W'(uniform_coord(LON_LIM));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int                      cur_bpc;
        int                      phase_bpc;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;

        // directed table: reset setting, extremes, range errors on each
        // side, clamping of the register, partial and whole groups
        probes = '{
            '{20, 0,           0,           1'b0, '0,       1'b0},
            '{20, LAT_LIM,     LON_LIM,     1'b0, '0,       1'b0},
            '{3,  0,           0,           1'b1, CHAR_S,   1'b0},
            '{3,  LAT_LIM,     LON_LIM,     1'b0, '0,       1'b0},
            '{3,  -LAT_LIM,    -LON_LIM,    1'b0, '0,       1'b0},
            '{3,  LAT_LIM + 1, 0,           1'b1, ERR_CHAR, 1'b1},
            '{3,  -LAT_LIM - 1, 0,          1'b1, ERR_CHAR, 1'b1},
            '{3,  0,           LON_LIM + 1, 1'b1, ERR_CHAR, 1'b1},
            '{3,  0,           -LON_LIM - 1, 1'b1, ERR_CHAR, 1'b1},
            '{3,  64'sd2147483647, -64'sd4294967296, 1'b1, ERR_CHAR, 1'b1},
            '{3,  -64'sd2147483648, 64'sd4294967295, 1'b1, ERR_CHAR, 1'b1},
            '{30, LAT_LIM,     -LON_LIM,    1'b0, '0,       1'b0},
            '{30, -LAT_LIM,    LON_LIM,     1'b0, '0,       1'b0},
            '{30, -1,          -1,          1'b0, '0,       1'b0},
            '{30, 0,           -1,          1'b0, '0,       1'b0},
            '{30, 305419896,   -64'sd2882400001, 1'b0, '0,  1'b0},
            '{0,  0,           0,           1'b0, '0,       1'b0},
            '{1,  123456789,   -987654321,  1'b0, '0,       1'b0},
            '{2,  -1,          1,           1'b0, '0,       1'b0},
            '{31, LAT_LIM - 1, LON_LIM - 1, 1'b0, '0,       1'b0},
            '{4,  777777777,   1234567890,  1'b0, '0,       1'b0},
            '{5,  -888888888,  -64'sd2222222222, 1'b0, '0,  1'b0},
            '{25, 42,          -42,         1'b0, '0,       1'b0},
            '{20, -LAT_LIM - 1, LON_LIM + 1, 1'b1, ERR_CHAR, 1'b1}
        };

        // single reset, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register must come up at its reset value
        check_bpc();
        cur_bpc = BPC_RESET;

        for (int i = 0; i < N_PROBES; i++) begin
            if (probes[i].bpc != cur_bpc) begin
                drain_block();
                set_bpc(probes[i].bpc);
                cur_bpc = probes[i].bpc;
            end
            send_word(LAT_W'(probes[i].lat), LON_W'(probes[i].lon), probes[i].known,
                      probes[i].k_char, probes[i].k_err, pick_gap(1'b0));
        end

        // random phases, each with its own setting; first two at the extremes
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_block();
            case (ph)
                0:       phase_bpc = MIN_BPC;
                1:       phase_bpc = MAX_BPC;
                default: phase_bpc = $urandom_range(0, 31);
            endcase
            set_bpc(phase_bpc);
            if (ph == PRESSURE_PH)
                pressure_go = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                make_location(lat, lon);
                send_word(lat, lon, 1'b0, '0, 1'b0, pick_gap(ph == BURST_PH));
            end
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
design/gh_pkg.sv
design/geohash_encoder.sv
sim/geohash_encoder_test.sv
